/* src/men_pkg.sv */
// Package for the mutual-exclusion node: event and message codes, shared-unit
// operation codes and the flag bundle returned by the shared unit.
// No dependencies; used by men_alu and mutual_exclusion_node.
`timescale 1ns / 1ps
`default_nettype none

package men_pkg;

    // Fixed field widths of the request and result channels
    localparam int OPCODE_W    = 2;
    localparam int STAMP_W     = 32;
    localparam int NODE_W      = 3;
    localparam int KIND_W      = 2;
    localparam int COUNT_W     = 32;
    localparam int NODE_CNT_W  = 4;
    localparam int CFG_DATA_W  = 4;
    localparam int CFG_INDEX_W = 1;

    // Event codes carried in s_tuser
    localparam logic [OPCODE_W-1:0] OP_LOCAL_REQ = 2'd0;
    localparam logic [OPCODE_W-1:0] OP_RECV_REQ  = 2'd1;
    localparam logic [OPCODE_W-1:0] OP_RECV_REP  = 2'd2;
    localparam logic [OPCODE_W-1:0] OP_EXIT      = 2'd3;

    // Message kinds carried in m_tuser
    localparam logic [KIND_W-1:0] KIND_NONE  = 2'd0;
    localparam logic [KIND_W-1:0] KIND_REQ   = 2'd1;
    localparam logic [KIND_W-1:0] KIND_REPLY = 2'd2;
    localparam logic [KIND_W-1:0] KIND_SKIP  = 2'd3;

    // Configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] REG_NODE_ID    = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] REG_NODE_COUNT = 1'b1;

    // Shared unit operations
    localparam logic [1:0] ALU_INC = 2'd0;
    localparam logic [1:0] ALU_MAX = 2'd1;
    localparam logic [1:0] ALU_CMP = 2'd2;

    typedef struct packed {
        logic lt;
        logic eq;
    } alu_flags_t;

endpackage

`default_nettype wire

/* src/men_alu.sv */
// Shared arithmetic unit of the mutual-exclusion node: increment, maximum and
// magnitude compare on one operand pair. Depends on men_pkg.
`timescale 1ns / 1ps
`default_nettype none

module men_alu #(
    parameter int W = 32
) (
    input  wire logic [1:0]   op,
    input  wire logic [W-1:0] a,
    input  wire logic [W-1:0] b,
    output logic [W-1:0]      result,
    output men_pkg::alu_flags_t flags
);

    logic lt;

    // One comparator serves both the maximum and the ordering test
    assign lt       = (a < b);
    assign flags.lt = lt;
    assign flags.eq = (a == b);

    // Select the operation result
    always_comb begin
        unique case (op)
            men_pkg::ALU_INC: result = a + W'(1);
            men_pkg::ALU_MAX: result = lt ? b : a;
            default:          result = a;
        endcase
    end

endmodule

`default_nettype wire

/* src/mutual_exclusion_node.sv */
// Top level of one mutual-exclusion node with a Lamport clock.
// Depends on men_pkg and men_alu.
//
// Usage: each request on the s_ channel is one event (s_tuser is the event code,
// s_tdata the timestamp and sender). The node answers on the m_ channel with
// one or more result items; m_tlast marks the final item of an event.
// Configuration (node id, node count) is written through cfg_we/cfg_index/
// cfg_data while the node is idle.
// Flow: s_tready is high only when the sequencer is idle; an event is taken as a
// request, then may use the shared add/compare unit (a received request uses it
// three times: max, increment, ordering test; an exit twice), then emits its
// result items. A local request also steps over the node's own id while scanning
// peers, without emitting an item, unless that id lies beyond the last peer.
// Results leave through an output register; when m_tready is low the sequencer
// holds the next item until the register frees, and no new event is taken
// until the last item of the current one is registered.
// Reset clears the clock, flags, reply marks and counters; the deferred queue
// is not cleared and needs no clearing pass, since only written entries are read.
`timescale 1ns / 1ps
`default_nettype none

module mutual_exclusion_node #(
    parameter int MAX_NODES  = 8,
    parameter int CLOCK_BITS = 32
) (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    // request channel
    input  wire logic         s_tvalid,
    output logic              s_tready,
    input  wire logic [39:0]  s_tdata,   // [31:0] msg_timestamp, [34:32] msg_sender, zero pad
    input  wire logic [1:0]   s_tuser,   // [1:0] opcode
    // result channel
    output logic              m_tvalid,
    input  wire logic         m_tready,
    output logic [103:0]      m_tdata,   // [2:0] dest_node, [34:3] out_timestamp,
                                         // [66:35] clock_value, [67] can_enter,
                                         // [99:68] entry_count, zero pad
    output logic [1:0]        m_tuser,   // [1:0] msg_kind
    output logic              m_tlast,
    // configuration
    input  wire logic         cfg_we,
    input  wire logic [0:0]   cfg_index,
    input  wire logic [3:0]   cfg_data
);

    localparam int W      = (CLOCK_BITS > 32) ? CLOCK_BITS : 32;
    localparam int QDEPTH = MAX_NODES - 1;
    localparam int QAW    = (MAX_NODES > 2) ? $clog2(MAX_NODES - 1) : 1;
    localparam int CW     = $clog2(MAX_NODES);

    // Sequencer states
    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_MAX  = 3'd1;
    localparam logic [2:0] ST_TICK = 3'd2;
    localparam logic [2:0] ST_PREC = 3'd3;
    localparam logic [2:0] ST_CNT  = 3'd4;
    localparam logic [2:0] ST_EMIT = 3'd5;

    // Emission modes
    localparam logic [1:0] EM_SINGLE = 2'd0;
    localparam logic [1:0] EM_REQ    = 2'd1;
    localparam logic [1:0] EM_EXIT   = 2'd2;

    // Configuration
    logic [2:0] node_id_reg;
    logic [3:0] node_count_reg;

    // Protocol state
    logic [CLOCK_BITS-1:0] clock_reg;
    logic                  pending_reg;
    logic [CLOCK_BITS-1:0] stamp_reg;
    logic [MAX_NODES-1:0]  marks_reg;
    logic [CW-1:0]         dcount_reg;
    logic [31:0]           exit_reg;
    logic [2:0]            queue_mem [0:QDEPTH-1];
    logic [2:0]            q_rdata_reg;

    // Sequencer
    logic [2:0]            state_reg;
    logic [1:0]            op_reg;
    logic [CLOCK_BITS-1:0] ts_reg;
    logic [2:0]            sender_reg;
    logic [CLOCK_BITS-1:0] tmp_reg;
    logic [1:0]            mode_reg;
    logic [1:0]            single_kind_reg;
    logic [2:0]            single_dest_reg;
    logic [3:0]            peer_reg;
    logic [3:0]            last_peer_reg;
    logic [CW-1:0]         q_reg;

    // Output register
    logic         out_valid_reg;
    logic [1:0]   out_kind_reg;
    logic [2:0]   out_dest_reg;
    logic [31:0]  out_ts_reg;
    logic [31:0]  out_clock_reg;
    logic         out_enter_reg;
    logic [31:0]  out_entry_reg;
    logic         out_last_reg;

    // Shared unit
    logic [1:0]          alu_op;
    logic [W-1:0]        alu_a;
    logic [W-1:0]        alu_b;
    logic [W-1:0]        alu_res;
    men_pkg::alu_flags_t alu_flags;

    logic                  accept;
    logic                  out_load;
    logic [W-1:0]          ts_in_w;
    logic [W-1:0]          clock_w;
    logic [W-1:0]          stamp_w;
    logic [3:0]            n_act;
    logic                  id_in;
    logic                  no_peers;
    logic [3:0]            last_peer;
    logic [MAX_NODES-1:0]  own_mask;
    logic [MAX_NODES-1:0]  sender_mask;
    logic [MAX_NODES-1:0]  miss;
    logic                  can_enter;
    logic                  precedes;
    logic [CW-1:0]         q_rd_addr;
    logic                  req_skip;

    assign accept   = s_tvalid && s_tready;
    assign s_tready = (state_reg == ST_IDLE);
    assign out_load = !out_valid_reg || m_tready;

    assign ts_in_w = W'(s_tdata[31:0]);
    assign clock_w = W'(clock_reg);
    assign stamp_w = W'(stamp_reg);

    // Active node count, clamped to the node limit
    always_comb begin
        if (32'(node_count_reg) > MAX_NODES) begin
            n_act = 4'(MAX_NODES);
        end else begin
            n_act = node_count_reg;
        end
    end

    assign id_in     = ({1'b0, node_id_reg} < n_act);
    assign no_peers  = (n_act == 4'd0) || ((n_act == 4'd1) && id_in);
    assign last_peer = ((n_act - 4'd1) == {1'b0, node_id_reg}) ? n_act - 4'd2 : n_act - 4'd1;

    // Per-node masks and the all-replied test
    always_comb begin
        for (int i = 0; i < MAX_NODES; i++) begin
            own_mask[i]    = (32'(node_id_reg) == i);
            sender_mask[i] = (32'(sender_reg) == i);
            miss[i]        = (i < 32'(n_act)) && (32'(node_id_reg) != i) && !marks_reg[i];
        end
    end
    assign can_enter = ~|miss;

    assign precedes = alu_flags.lt || (alu_flags.eq && (sender_reg < node_id_reg));
    assign req_skip = (peer_reg == {1'b0, node_id_reg});

    // Drive the shared unit from the sequencer state
    always_comb begin
        alu_op = men_pkg::ALU_INC;
        alu_a  = clock_w;
        alu_b  = W'(ts_reg);
        unique case (state_reg)
            ST_MAX: begin
                alu_op = men_pkg::ALU_MAX;
            end
            ST_TICK: begin
                alu_a = (op_reg == men_pkg::OP_RECV_REQ) ? W'(tmp_reg) : clock_w;
            end
            ST_PREC: begin
                alu_op = men_pkg::ALU_CMP;
                alu_a  = W'(ts_reg);
                alu_b  = stamp_w;
            end
            ST_CNT: begin
                alu_a = W'(exit_reg);
            end
            default: begin
                alu_op = men_pkg::ALU_INC;
            end
        endcase
    end

    men_alu #(
        .W (W)
    ) u_alu (
        .op     (alu_op),
        .a      (alu_a),
        .b      (alu_b),
        .result (alu_res),
        .flags  (alu_flags)
    );

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            node_id_reg    <= 3'd0;
            node_count_reg <= 4'd8;
        end else if (cfg_we) begin
            unique case (cfg_index)
                men_pkg::REG_NODE_ID:    node_id_reg    <= cfg_data[2:0];
                men_pkg::REG_NODE_COUNT: node_count_reg <= cfg_data;
                default:                 node_id_reg    <= node_id_reg;
            endcase
        end
    end

    // Deferred queue: write on defer, registered read that runs one entry ahead;
    // point the read at the head while the exit count is taken
    assign q_rd_addr = (state_reg == ST_CNT) ? CW'(0)
                     : (state_reg == ST_EMIT && mode_reg == EM_EXIT && out_load)
                     ? q_reg + CW'(1) : q_reg;

    always_ff @(posedge aclk) begin
        if (state_reg == ST_PREC && pending_reg && !precedes
            && (32'(dcount_reg) < MAX_NODES - 1)) begin
            queue_mem[dcount_reg[QAW-1:0]] <= sender_reg;
        end
        q_rdata_reg <= queue_mem[q_rd_addr[QAW-1:0]];
    end

    // Event payload capture
    always_ff @(posedge aclk) begin
        if (accept) begin
            op_reg     <= s_tuser;
            ts_reg     <= ts_in_w[CLOCK_BITS-1:0];
            sender_reg <= s_tdata[34:32];
        end
        if (state_reg == ST_MAX) begin
            tmp_reg <= alu_res[CLOCK_BITS-1:0];
        end
    end

    // Sequencer and protocol state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= ST_IDLE;
            clock_reg       <= '0;
            pending_reg     <= 1'b0;
            stamp_reg       <= '0;
            marks_reg       <= '0;
            dcount_reg      <= '0;
            exit_reg        <= '0;
            mode_reg        <= EM_SINGLE;
            single_kind_reg <= men_pkg::KIND_NONE;
            single_dest_reg <= 3'd0;
            peer_reg        <= 4'd0;
            last_peer_reg   <= 4'd0;
            q_reg           <= '0;
        end else begin
            unique case (state_reg)
                ST_IDLE: begin
                    if (accept) begin
                        priority if (s_tuser == men_pkg::OP_LOCAL_REQ && pending_reg) begin
                            mode_reg        <= EM_SINGLE;
                            single_kind_reg <= men_pkg::KIND_SKIP;
                            single_dest_reg <= 3'd0;
                            state_reg       <= ST_EMIT;
                        end else if (s_tuser == men_pkg::OP_RECV_REQ) begin
                            state_reg <= ST_MAX;
                        end else begin
                            state_reg <= ST_TICK;
                        end
                    end
                end
                ST_MAX: begin
                    state_reg <= ST_TICK;
                end
                ST_TICK: begin
                    clock_reg       <= alu_res[CLOCK_BITS-1:0];
                    single_kind_reg <= men_pkg::KIND_NONE;
                    single_dest_reg <= 3'd0;
                    unique case (op_reg)
                        men_pkg::OP_LOCAL_REQ: begin
                            pending_reg   <= 1'b1;
                            stamp_reg     <= alu_res[CLOCK_BITS-1:0];
                            marks_reg     <= own_mask;
                            peer_reg      <= 4'd0;
                            last_peer_reg <= last_peer;
                            mode_reg      <= no_peers ? EM_SINGLE : EM_REQ;
                            state_reg     <= ST_EMIT;
                        end
                        men_pkg::OP_RECV_REQ: begin
                            mode_reg  <= EM_SINGLE;
                            state_reg <= ST_PREC;
                        end
                        men_pkg::OP_RECV_REP: begin
                            marks_reg <= marks_reg | sender_mask;
                            mode_reg  <= EM_SINGLE;
                            state_reg <= ST_EMIT;
                        end
                        default: begin
                            mode_reg  <= EM_SINGLE;
                            state_reg <= ST_CNT;
                        end
                    endcase
                end
                ST_PREC: begin
                    // Reply now, or defer the sender while there is room
                    state_reg <= ST_EMIT;
                    if (!pending_reg || precedes) begin
                        single_kind_reg <= men_pkg::KIND_REPLY;
                        single_dest_reg <= sender_reg;
                    end else if (32'(dcount_reg) < MAX_NODES - 1) begin
                        dcount_reg <= dcount_reg + CW'(1);
                    end
                end
                ST_CNT: begin
                    exit_reg    <= alu_res[31:0];
                    pending_reg <= 1'b0;
                    q_reg       <= '0;
                    state_reg   <= ST_EMIT;
                    if (dcount_reg != '0) begin
                        mode_reg <= EM_EXIT;
                    end
                end
                ST_EMIT: begin
                    unique case (mode_reg)
                        EM_REQ: begin
                            // Step past own id, otherwise advance once the item is taken
                            if (req_skip) begin
                                peer_reg <= peer_reg + 4'd1;
                            end else if (out_load) begin
                                if (peer_reg == last_peer_reg) begin
                                    state_reg <= ST_IDLE;
                                end else begin
                                    peer_reg <= peer_reg + 4'd1;
                                end
                            end
                        end
                        EM_EXIT: begin
                            if (out_load) begin
                                if (q_reg == dcount_reg - CW'(1)) begin
                                    dcount_reg <= '0;
                                    state_reg  <= ST_IDLE;
                                end else begin
                                    q_reg <= q_reg + CW'(1);
                                end
                            end
                        end
                        default: begin
                            if (out_load) begin
                                state_reg <= ST_IDLE;
                            end
                        end
                    endcase
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    // Output register: valid flag
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (out_load) begin
            out_valid_reg <= (state_reg == ST_EMIT) && !(mode_reg == EM_REQ && req_skip);
        end
    end

    // Output register: payload
    always_ff @(posedge aclk) begin
        if (out_load && state_reg == ST_EMIT) begin
            out_clock_reg <= clock_w[31:0];
            out_enter_reg <= can_enter;
            out_entry_reg <= exit_reg;
            unique case (mode_reg)
                EM_REQ: begin
                    out_kind_reg <= men_pkg::KIND_REQ;
                    out_dest_reg <= peer_reg[2:0];
                    out_ts_reg   <= stamp_w[31:0];
                    out_last_reg <= (peer_reg == last_peer_reg);
                end
                EM_EXIT: begin
                    out_kind_reg <= men_pkg::KIND_REPLY;
                    out_dest_reg <= q_rdata_reg;
                    out_ts_reg   <= 32'd0;
                    out_last_reg <= (q_reg == dcount_reg - CW'(1));
                end
                default: begin
                    out_kind_reg <= single_kind_reg;
                    out_dest_reg <= single_dest_reg;
                    out_ts_reg   <= 32'd0;
                    out_last_reg <= 1'b1;
                end
            endcase
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_kind_reg;
    assign m_tlast  = out_last_reg;
    assign m_tdata  = {4'd0, out_entry_reg, out_enter_reg, out_clock_reg,
                       out_ts_reg, out_dest_reg};

endmodule

`default_nettype wire
